// File: hdl/segx_pkg.sv
package segx_pkg;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_MISS     = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [31:0] a_start_x;
    logic signed [31:0] a_start_y;
    logic signed [31:0] a_end_x;
    logic signed [31:0] a_end_y;
    logic signed [31:0] b_start_x;
    logic signed [31:0] b_start_y;
    logic signed [31:0] b_end_x;
    logic signed [31:0] b_end_y;
  } seg_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
  } seg_res_t;

endpackage

// File: hdl/segx_div.sv
// Pipelined restoring divider: one quotient bit per stage, QB stages.
// The top DW bits of the numerator must already be below the divisor.
module segx_div #(
  parameter int DW = 67,
  parameter int QB = 33
) (
  input  logic             clk_i,
  input  logic [DW+QB-1:0] num_i,
  input  logic [DW-1:0]    den_i,
  output logic [QB-1:0]    quo_o
);

  logic [DW-1:0] rem_q [QB];
  logic [QB-1:0] low_q [QB];
  logic [QB-1:0] quo_q [QB];
  logic [DW-1:0] den_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QB-1:0] low_in;
    logic [QB-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i[DW+QB-1:QB];
      assign low_in = num_i[QB-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    always_comb begin
      trial = {rem_in, low_in[QB-1]};
      diff  = trial - {1'b0, den_in};
      ge    = (trial >= {1'b0, den_in});
    end

    // Advance remainder, shift out one numerator bit, shift in one quotient bit.
    always_ff @(posedge clk_i) begin
      rem_q[k] <= ge ? diff[DW-1:0] : trial[DW-1:0];
      low_q[k] <= {low_in[QB-2:0], 1'b0};
      quo_q[k] <= {quo_in[QB-2:0], ge};
      den_q[k] <= den_in;
    end
  end

  assign quo_o = quo_q[QB-1];

endmodule

// File: hdl/segment_intersection_top.sv
// Two-segment intersection in the plane, fully pipelined.
//
// Input channel: raise start with one segment pair on in_i; the beat is
// taken at every rising edge where start is high and busy is low. busy is
// tied low: a new pair may enter every cycle, 1 beat per cycle sustained.
// Result channel: done_o marks res_o for exactly one cycle. The receiver
// cannot stall, so nothing is held back. Each pair passes six stages of
// differences, cross products, sums, sign correction and the split
// numerator multiply, then the two pipelined restoring dividers, one
// quotient bit per stage over COORD_BITS + 1 stages.
// status: 0 intersects, 1 parallel or collinear, 2 no overlap; the point is
// zero unless status is 0. Only the low COORD_BITS bits of each coordinate
// are used, sign-extended.
// Reset clears the valid bits of every stage; items in flight are dropped
// and no result strobes until new pairs arrive.
module segment_intersection_top
  import segx_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  seg_in_t  in_i,
  output logic     done_o,
  output seg_res_t res_o
);

  localparam int DFW = COORD_BITS + 1;   // coordinate difference
  localparam int PW  = 2 * DFW;          // one cross product
  localparam int DW  = PW + 1;           // den, tn, un
  localparam int QB  = DFW;              // quotient bits
  localparam int NW  = DW + QB;          // dividend
  localparam int HL  = (DW + 1) / 2;     // low slice of tn
  localparam int HH  = DW - HL;          // high slice of tn

  typedef logic signed [DFW-1:0] diff_t;
  typedef logic signed [COORD_BITS-1:0] crd_t;

  function automatic diff_t ext(logic [31:0] v);
    crd_t c;
    c   = v[COORD_BITS-1:0];
    ext = DFW'(c);
  endfunction

  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // ---- stage 1: differences ----
  logic  v1_q;
  diff_t dx12_q, dy12_q, dx13_q, dy13_q, dx34_q, dy34_q, dx21_q, dy21_q;
  crd_t  x1_1_q, y1_1_q;

  always_ff @(posedge clk_i) begin
    dx12_q <= ext(in_i.a_start_x) - ext(in_i.a_end_x);
    dy12_q <= ext(in_i.a_start_y) - ext(in_i.a_end_y);
    dx13_q <= ext(in_i.a_start_x) - ext(in_i.b_start_x);
    dy13_q <= ext(in_i.a_start_y) - ext(in_i.b_start_y);
    dx34_q <= ext(in_i.b_start_x) - ext(in_i.b_end_x);
    dy34_q <= ext(in_i.b_start_y) - ext(in_i.b_end_y);
    dx21_q <= ext(in_i.a_end_x) - ext(in_i.a_start_x);
    dy21_q <= ext(in_i.a_end_y) - ext(in_i.a_start_y);
    x1_1_q <= in_i.a_start_x[COORD_BITS-1:0];
    y1_1_q <= in_i.a_start_y[COORD_BITS-1:0];
  end

  // ---- stage 2: six cross products ----
  logic                 v2_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p4_q, p5_q, p6_q;
  diff_t                dx21_2_q, dy21_2_q;
  crd_t                 x1_2_q, y1_2_q;

  always_ff @(posedge clk_i) begin
    p1_q     <= dx12_q * dy34_q;
    p2_q     <= dy12_q * dx34_q;
    p3_q     <= dx13_q * dy34_q;
    p4_q     <= dy13_q * dx34_q;
    p5_q     <= dy12_q * dx13_q;
    p6_q     <= dx12_q * dy13_q;
    dx21_2_q <= dx21_q;
    dy21_2_q <= dy21_q;
    x1_2_q   <= x1_1_q;
    y1_2_q   <= y1_1_q;
  end

  // ---- stage 3: denominator and numerators ----
  logic                 v3_q;
  logic signed [DW-1:0] den_q, tn_q, un_q;
  diff_t                dx21_3_q, dy21_3_q;
  crd_t                 x1_3_q, y1_3_q;

  always_ff @(posedge clk_i) begin
    den_q    <= DW'(p1_q) - DW'(p2_q);
    tn_q     <= DW'(p3_q) - DW'(p4_q);
    un_q     <= DW'(p5_q) - DW'(p6_q);
    dx21_3_q <= dx21_2_q;
    dy21_3_q <= dy21_2_q;
    x1_3_q   <= x1_2_q;
    y1_3_q   <= y1_2_q;
  end

  // ---- stage 4: sign correction and range test ----
  logic [DW-1:0] aden_d, atn_d, aun_d;
  status_e       st_d;

  always_comb begin
    aden_d = den_q[DW-1] ? -den_q : den_q;
    atn_d  = den_q[DW-1] ? -tn_q  : tn_q;
    aun_d  = den_q[DW-1] ? -un_q  : un_q;
    if (den_q == '0) begin
      st_d = ST_PARALLEL;
    end else if (atn_d[DW-1] || aun_d[DW-1] || (atn_d > aden_d) || (aun_d > aden_d)) begin
      st_d = ST_MISS;
    end else begin
      st_d = ST_HIT;
    end
  end

  logic           v4_q;
  logic [DW-1:0]  aden_4_q, atn_4_q;
  status_e        st_4_q;
  logic [DFW-1:0] mx_4_q, my_4_q;
  logic           sx_4_q, sy_4_q;
  crd_t           x1_4_q, y1_4_q;

  always_ff @(posedge clk_i) begin
    aden_4_q <= aden_d;
    atn_4_q  <= atn_d;
    st_4_q   <= st_d;
    mx_4_q   <= dx21_3_q[DFW-1] ? -dx21_3_q : dx21_3_q;
    my_4_q   <= dy21_3_q[DFW-1] ? -dy21_3_q : dy21_3_q;
    sx_4_q   <= dx21_3_q[DFW-1];
    sy_4_q   <= dy21_3_q[DFW-1];
    x1_4_q   <= x1_3_q;
    y1_4_q   <= y1_3_q;
  end

  // ---- stage 5: tn times |d| as two partial products per axis ----
  logic              v5_q;
  logic [HL+DFW-1:0] plx_q, ply_q;
  logic [HH+DFW-1:0] phx_q, phy_q;
  logic [DW-1:0]     aden_5_q;
  status_e           st_5_q;
  logic              sx_5_q, sy_5_q;
  crd_t              x1_5_q, y1_5_q;

  always_ff @(posedge clk_i) begin
    plx_q    <= (HL+DFW)'(atn_4_q[HL-1:0]) * (HL+DFW)'(mx_4_q);
    ply_q    <= (HL+DFW)'(atn_4_q[HL-1:0]) * (HL+DFW)'(my_4_q);
    phx_q    <= (HH+DFW)'(atn_4_q[DW-1:HL]) * (HH+DFW)'(mx_4_q);
    phy_q    <= (HH+DFW)'(atn_4_q[DW-1:HL]) * (HH+DFW)'(my_4_q);
    aden_5_q <= aden_4_q;
    st_5_q   <= st_4_q;
    sx_5_q   <= sx_4_q;
    sy_5_q   <= sy_4_q;
    x1_5_q   <= x1_4_q;
    y1_5_q   <= y1_4_q;
  end

  // ---- stage 6: combine partial products ----
  logic          v6_q;
  logic [NW-1:0] nx_q, ny_q;
  logic [DW-1:0] aden_6_q;
  status_e       st_6_q;
  logic          sx_6_q, sy_6_q;
  crd_t          x1_6_q, y1_6_q;

  always_ff @(posedge clk_i) begin
    nx_q     <= {phx_q, {HL{1'b0}}} + NW'(plx_q);
    ny_q     <= {phy_q, {HL{1'b0}}} + NW'(ply_q);
    aden_6_q <= aden_5_q;
    st_6_q   <= st_5_q;
    sx_6_q   <= sx_5_q;
    sy_6_q   <= sy_5_q;
    x1_6_q   <= x1_5_q;
    y1_6_q   <= y1_5_q;
  end

  // ---- dividers: den is nonzero on every hit; other lanes are discarded ----
  logic [QB-1:0] qx, qy;

  segx_div #(.DW(DW), .QB(QB)) u_div_x (
    .clk_i (clk_i),
    .num_i (nx_q),
    .den_i (aden_6_q),
    .quo_o (qx)
  );

  segx_div #(.DW(DW), .QB(QB)) u_div_y (
    .clk_i (clk_i),
    .num_i (ny_q),
    .den_i (aden_6_q),
    .quo_o (qy)
  );

  // Side data travels alongside the divider stages.
  status_e st_dq [QB];
  logic    sx_dq [QB];
  logic    sy_dq [QB];
  crd_t    x1_dq [QB];
  crd_t    y1_dq [QB];
  logic    vd_q  [QB];

  always_ff @(posedge clk_i) begin
    st_dq[0] <= st_6_q;
    sx_dq[0] <= sx_6_q;
    sy_dq[0] <= sy_6_q;
    x1_dq[0] <= x1_6_q;
    y1_dq[0] <= y1_6_q;
    for (int k = 1; k < QB; k++) begin
      st_dq[k] <= st_dq[k-1];
      sx_dq[k] <= sx_dq[k-1];
      sy_dq[k] <= sy_dq[k-1];
      x1_dq[k] <= x1_dq[k-1];
      y1_dq[k] <= y1_dq[k-1];
    end
  end

  // ---- output: start plus signed quotient, zero unless a hit ----
  logic [31:0] qx32, qy32, cx_d, cy_d;

  always_comb begin
    qx32 = 32'(qx);
    qy32 = 32'(qy);
    cx_d = 32'(x1_dq[QB-1]) + (sx_dq[QB-1] ? -qx32 : qx32);
    cy_d = 32'(y1_dq[QB-1]) + (sy_dq[QB-1] ? -qy32 : qy32);
  end

  seg_res_t res_q;

  always_ff @(posedge clk_i) begin
    res_q.status <= st_dq[QB-1];
    if (st_dq[QB-1] == ST_HIT) begin
      res_q.cross_x <= cx_d;
      res_q.cross_y <= cy_d;
    end else begin
      res_q.cross_x <= '0;
      res_q.cross_y <= '0;
    end
  end

  // Valid bits: advance every cycle, drop on reset.
  logic done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      v6_q   <= 1'b0;
      done_q <= 1'b0;
      for (int k = 0; k < QB; k++) begin
        vd_q[k] <= 1'b0;
      end
    end else begin
      v1_q    <= accept;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      vd_q[0] <= v6_q;
      for (int k = 1; k < QB; k++) begin
        vd_q[k] <= vd_q[k-1];
      end
      done_q  <= vd_q[QB-1];
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
